/* rtl/pba_pkg.sv */
`timescale 1ns / 1ps
// Package for the proximity beep alert block: register set, lane command,
// state encodings and fixed widths. Used by every module of the block.

package pba_pkg;

    localparam int DIST_W  = 13;
    localparam int IR_W    = 12;
    localparam int PER_W   = 16;
    localparam int TIME_W  = 32;
    localparam int NUM_W   = 29;
    localparam int PROD_W  = 31;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 16;
    localparam int STEP_W  = 5;

    localparam logic [DIST_W-1:0] DIST_SAT = 13'd4800;

    localparam logic [IR_W-1:0]   RST_IR_THRESHOLD = 12'd1000;
    localparam logic [DIST_W-1:0] RST_START_DIST   = 13'd320;
    localparam logic [DIST_W-1:0] RST_FULL_DIST    = 13'd80;
    localparam logic [DIST_W-1:0] RST_MIN_DIST     = 13'd32;
    localparam logic [PER_W-1:0]  RST_SLOW_PERIOD  = 16'd400;
    localparam logic [PER_W-1:0]  RST_FAST_PERIOD  = 16'd80;

    typedef enum logic [CIDX_W-1:0] {
        REG_IR_THRESHOLD = 3'd0,
        REG_START_DIST   = 3'd1,
        REG_FULL_DIST    = 3'd2,
        REG_MIN_DIST     = 3'd3,
        REG_SLOW_PERIOD  = 3'd4,
        REG_FAST_PERIOD  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [IR_W-1:0]   ir_threshold;
        logic [DIST_W-1:0] start_dist;
        logic [DIST_W-1:0] full_dist;
        logic [DIST_W-1:0] min_dist;
        logic [PER_W-1:0]  slow_period_ms;
        logic [PER_W-1:0]  fast_period_ms;
    } cfg_t;

    typedef struct packed {
        logic              force_on;
        logic              valid;
        logic [DIST_W-1:0] distance;
    } lane_cmd_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_SUB,
        L_DIV
    } lane_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_PEND
    } top_state_t;

endpackage

/* rtl/pba_div.sv */
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle, for the blink period.
// Depends on pba_pkg for its widths; the quotient must fit in PER_W bits.

module pba_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pba_pkg::NUM_W-1:0]       dividend,
    input  logic [pba_pkg::DIST_W-1:0]      divisor,
    output logic                            done,
    output logic [pba_pkg::PER_W-1:0]       quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [pba_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic [pba_pkg::DIST_W-1:0]        rem_reg, rem_next;
    logic [pba_pkg::PER_W-1:0]         quo_reg, quo_next;
    logic [pba_pkg::DIST_W:0]          trial;
    logic [pba_pkg::DIST_W:0]          shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign shifted = {rem_reg, quo_reg[pba_pkg::PER_W-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = pba_pkg::STEP_W'(pba_pkg::PER_W - 1);
            rem_next  = dividend[pba_pkg::NUM_W-1:pba_pkg::PER_W];
            quo_next  = dividend[pba_pkg::PER_W-1:0];
        end else if (busy_reg) begin
            if (shifted >= {1'b0, divisor}) begin
                rem_next = trial[pba_pkg::DIST_W-1:0];
                quo_next = {quo_reg[pba_pkg::PER_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[pba_pkg::DIST_W-1:0];
                quo_next = {quo_reg[pba_pkg::PER_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/pba_lane.sv */
`timescale 1ns / 1ps
// One alert channel: classifies its distance, computes the blink period and
// keeps the channel level and last toggle time. Uses pba_pkg and pba_div.

module pba_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  pba_pkg::lane_cmd_t            cmd,
    input  logic [pba_pkg::TIME_W-1:0]    now_ms,
    input  pba_pkg::cfg_t                 cfg,
    output logic                          busy,
    output logic                          level
);

    pba_pkg::lane_state_t                 state_reg, state_next;
    logic                                 level_reg, level_next;
    logic [pba_pkg::TIME_W-1:0]           last_reg, last_next;
    logic [pba_pkg::DIST_W-1:0]           dist_reg, dist_next;
    logic [pba_pkg::TIME_W-1:0]           now_reg, now_next;
    logic [pba_pkg::NUM_W-1:0]            p1_reg, p1_next;
    logic signed [pba_pkg::PROD_W-1:0]    p2_reg, p2_next;
    logic [pba_pkg::DIST_W-1:0]           span;
    logic [pba_pkg::DIST_W-1:0]           sd;
    logic signed [pba_pkg::PER_W:0]       diff;
    logic signed [pba_pkg::PROD_W-1:0]    num_full;
    logic                                 div_start;
    logic                                 div_done;
    logic [pba_pkg::PER_W-1:0]            quotient;
    logic [pba_pkg::TIME_W-1:0]           elapsed;
    logic [pba_pkg::TIME_W-1:0]           half;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pba_pkg::L_IDLE;
            level_reg <= 1'b0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            last_reg  <= last_next;
        end
        dist_reg <= dist_next;
        now_reg  <= now_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
    end

    assign span     = cfg.start_dist - cfg.full_dist;
    assign sd       = cfg.start_dist - dist_reg;
    assign diff     = $signed({1'b0, cfg.slow_period_ms}) - $signed({1'b0, cfg.fast_period_ms});
    assign num_full = $signed({2'b00, p1_reg}) - p2_reg;
    assign elapsed  = now_reg - last_reg;
    assign half     = {{(pba_pkg::TIME_W-pba_pkg::PER_W+1){1'b0}},
                       quotient[pba_pkg::PER_W-1:1]};

    always_comb begin
        state_next = state_reg;
        level_next = level_reg;
        last_next  = last_reg;
        dist_next  = dist_reg;
        now_next   = now_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            pba_pkg::L_IDLE: begin
                if (start) begin
                    if (cmd.force_on) begin
                        level_next = 1'b1;
                    end else if (!cmd.valid || cmd.distance > cfg.start_dist) begin
                        level_next = 1'b0;
                        last_next  = now_ms;
                    end else if (cmd.distance <= cfg.full_dist) begin
                        level_next = 1'b1;
                    end else begin
                        dist_next  = cmd.distance;
                        now_next   = now_ms;
                        state_next = pba_pkg::L_MUL;
                    end
                end
            end
            pba_pkg::L_MUL: begin
                p1_next = {{(pba_pkg::NUM_W-pba_pkg::PER_W){1'b0}}, cfg.slow_period_ms}
                        * {{(pba_pkg::NUM_W-pba_pkg::DIST_W){1'b0}}, span};
                p2_next = $signed({{(pba_pkg::PROD_W-pba_pkg::DIST_W){1'b0}}, sd})
                        * $signed({{(pba_pkg::PROD_W-pba_pkg::PER_W-1){diff[pba_pkg::PER_W]}},
                                   diff});
                state_next = pba_pkg::L_SUB;
            end
            pba_pkg::L_SUB: begin
                div_start  = 1'b1;
                state_next = pba_pkg::L_DIV;
            end
            pba_pkg::L_DIV: begin
                if (div_done) begin
                    if (elapsed >= half) begin
                        level_next = ~level_reg;
                        last_next  = now_reg;
                    end
                    state_next = pba_pkg::L_IDLE;
                end
            end
            default: begin
                state_next = pba_pkg::L_IDLE;
            end
        endcase
    end

    pba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_full[pba_pkg::NUM_W-1:0]),
        .divisor  (span),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy  = (state_reg != pba_pkg::L_IDLE);
    assign level = level_reg;

endmodule

/* rtl/proximity_beep_alert.sv */
`timescale 1ns / 1ps
// Top level of the proximity beep alert: register file, input decode, three
// channel lanes (buzzer, left LED, right LED) and the result register.
// Depends on pba_pkg and pba_lane.
//
//  Channel   Direction  Payload
//  s_*       in         readings: IR value and flag, two distances and flags, time
//  m_*       out        drive levels: buzzer, left LED, right LED
//  cfg_*     in         register writes: index and 16-bit data
//
// An item that leaves every channel off, steady or forced on passes through the
// T_BUSY state into the result register; an item with a blinking channel also
// waits for the 16-step serial divider in each lane after the multiply and
// subtract stages. One item is in work at a time, and while the output stalls
// it holds in T_PEND; the result register lets the next item be taken while the
// previous result waits. Reset is synchronous on aresetn and restores all
// register defaults.

module proximity_beep_alert (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ir_raw[11:0], ir_ok[12], left_dist[25:13], left_ok[26], right_dist[39:27],
    // right_ok[40], now_ms[72:41], zero fill above.
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // buzzer_on[0], left_led_on[1], right_led_on[2], zero fill above.
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pba_pkg::cfg_t                      cfg_reg, cfg_next;
    pba_pkg::top_state_t                state_reg, state_next;
    logic                               m_valid_reg, m_valid_next;
    logic [2:0]                         m_data_reg, m_data_next;

    logic [pba_pkg::IR_W-1:0]           ir_raw;
    logic                               ir_ok;
    logic [pba_pkg::DIST_W-1:0]         left_raw, right_raw;
    logic [pba_pkg::DIST_W-1:0]         left_d, right_d, buzz_d;
    logic                               left_ok, right_ok;
    logic                               left_c, right_c;
    logic [pba_pkg::TIME_W-1:0]         now_ms;
    logic                               ir_alert;
    logic                               start;
    logic                               out_free;
    pba_pkg::lane_cmd_t                 cmd_buzz, cmd_left, cmd_right;
    logic [2:0]                         lane_busy;
    logic [2:0]                         lane_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ir_threshold   <= pba_pkg::RST_IR_THRESHOLD;
            cfg_reg.start_dist     <= pba_pkg::RST_START_DIST;
            cfg_reg.full_dist      <= pba_pkg::RST_FULL_DIST;
            cfg_reg.min_dist       <= pba_pkg::RST_MIN_DIST;
            cfg_reg.slow_period_ms <= pba_pkg::RST_SLOW_PERIOD;
            cfg_reg.fast_period_ms <= pba_pkg::RST_FAST_PERIOD;
            state_reg              <= pba_pkg::T_IDLE;
            m_valid_reg            <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pba_pkg::REG_IR_THRESHOLD: cfg_next.ir_threshold   = cfg_data[pba_pkg::IR_W-1:0];
                pba_pkg::REG_START_DIST:   cfg_next.start_dist     = cfg_data[pba_pkg::DIST_W-1:0];
                pba_pkg::REG_FULL_DIST:    cfg_next.full_dist      = cfg_data[pba_pkg::DIST_W-1:0];
                pba_pkg::REG_MIN_DIST:     cfg_next.min_dist       = cfg_data[pba_pkg::DIST_W-1:0];
                pba_pkg::REG_SLOW_PERIOD:  cfg_next.slow_period_ms = cfg_data;
                pba_pkg::REG_FAST_PERIOD:  cfg_next.fast_period_ms = cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign ir_raw    = s_tdata[11:0];
    assign ir_ok     = s_tdata[12];
    assign left_raw  = s_tdata[25:13];
    assign left_ok   = s_tdata[26];
    assign right_raw = s_tdata[39:27];
    assign right_ok  = s_tdata[40];
    assign now_ms    = s_tdata[72:41];

    assign left_d   = (left_raw > pba_pkg::DIST_SAT) ? pba_pkg::DIST_SAT : left_raw;
    assign right_d  = (right_raw > pba_pkg::DIST_SAT) ? pba_pkg::DIST_SAT : right_raw;
    assign ir_alert = ir_ok && (ir_raw < cfg_reg.ir_threshold);
    assign left_c   = left_ok && (left_d >= cfg_reg.min_dist);
    assign right_c  = right_ok && (right_d >= cfg_reg.min_dist);

    always_comb begin
        if (left_c && right_c) begin
            buzz_d = (right_d < left_d) ? right_d : left_d;
        end else if (left_c) begin
            buzz_d = left_d;
        end else if (right_c) begin
            buzz_d = right_d;
        end else begin
            buzz_d = '0;
        end
    end

    assign cmd_buzz  = '{force_on: ir_alert, valid: left_c || right_c, distance: buzz_d};
    assign cmd_left  = '{force_on: ir_alert, valid: left_ok, distance: left_d};
    assign cmd_right = '{force_on: ir_alert, valid: right_ok, distance: right_d};

    assign s_tready = (state_reg == pba_pkg::T_IDLE);
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    pba_lane u_lane_buzz (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cmd     (cmd_buzz),
        .now_ms  (now_ms),
        .cfg     (cfg_reg),
        .busy    (lane_busy[0]),
        .level   (lane_level[0])
    );

    pba_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cmd     (cmd_left),
        .now_ms  (now_ms),
        .cfg     (cfg_reg),
        .busy    (lane_busy[1]),
        .level   (lane_level[1])
    );

    pba_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .cmd     (cmd_right),
        .now_ms  (now_ms),
        .cfg     (cfg_reg),
        .busy    (lane_busy[2]),
        .level   (lane_level[2])
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            pba_pkg::T_IDLE: begin
                if (start) begin
                    state_next = pba_pkg::T_BUSY;
                end
            end
            pba_pkg::T_BUSY, pba_pkg::T_PEND: begin
                if (lane_busy == 3'b000) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = lane_level;
                        state_next   = pba_pkg::T_IDLE;
                    end else begin
                        state_next = pba_pkg::T_PEND;
                    end
                end
            end
            default: begin
                state_next = pba_pkg::T_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_data_reg};

endmodule
